>>> sv/lsm_pkg.sv
package lsm_pkg;

	// Configuration port geometry
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_SPIKE_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_ALERT_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_ALERT_ENABLE    = 2'd2;

	// Register reset values
	localparam logic [15:0] SPIKE_THRESHOLD_RST = 16'd200;
	localparam logic [15:0] ALERT_THRESHOLD_RST = 16'd200;

	// Fixed floor of the latency jump detector
	localparam logic [15:0] JUMP_FLOOR_MS = 16'd50;

	typedef struct packed {
		logic [15:0] spike_threshold;
		logic [15:0] alert_threshold;
		logic        alert_enable;
	} cfg_t;

	// One sample as held in the input stage
	typedef struct packed {
		logic        timed_out;
		logic [15:0] rtt;
		logic [31:0] rtt_sq;
	} sample_t;

	typedef struct packed {
		logic lost;
		logic reconnect;
		logic doubled;
		logic persistent_high;
		logic alert;
	} events_t;

endpackage

>>> sv/lsm_cfg.sv
module lsm_cfg
	import lsm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic        wr_en;
	logic [1:0]  reg_idx;
	cfg_t        cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// Write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spike_threshold <= SPIKE_THRESHOLD_RST;
			cfg_q.alert_threshold <= ALERT_THRESHOLD_RST;
			cfg_q.alert_enable    <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SPIKE_THRESHOLD: cfg_q.spike_threshold <= pwdata[15:0];
				REG_ALERT_THRESHOLD: cfg_q.alert_threshold <= pwdata[15:0];
				REG_ALERT_ENABLE:    cfg_q.alert_enable    <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_SPIKE_THRESHOLD: prdata = {16'd0, cfg_q.spike_threshold};
			REG_ALERT_THRESHOLD: prdata = {16'd0, cfg_q.alert_threshold};
			REG_ALERT_ENABLE:    prdata = {31'd0, cfg_q.alert_enable};
			default:             prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> sv/lsm_update.sv
module lsm_update
	import lsm_pkg::*;
#(
	parameter int HIGH_RUN_LIMIT = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        upd_en,
	input  sample_t     smp,
	input  cfg_t        cfg,
	output logic [31:0] total_sent,
	output logic [31:0] total_lost,
	output logic [47:0] latency_sum,
	output logic [63:0] latency_square_sum,
	output logic [47:0] jitter_sum,
	output logic [15:0] min_rtt,
	output logic [15:0] max_rtt,
	output events_t     ev
);

	localparam int RUN_W = $clog2(HIGH_RUN_LIMIT + 1);

	logic [31:0]      sent_q, lost_q;
	logic [47:0]      sum_q, jit_q;
	logic [63:0]      sq_q;
	logic [15:0]      min_q, max_q;
	logic             prev_valid_q;
	logic [15:0]      prev_q;
	logic [RUN_W-1:0] run_q;
	events_t          ev_q;

	logic [31:0]      sent_nx, lost_nx;
	logic [48:0]      sum_add, jit_add;
	logic [64:0]      sq_add;
	logic [15:0]      diff;
	logic [RUN_W-1:0] run_inc, run_nx;
	logic             over_spike, run_hit;
	events_t          ev_nx;

	// Saturating counters
	assign sent_nx = (&sent_q) ? sent_q : sent_q + 32'd1;
	assign lost_nx = (&lost_q) ? lost_q : lost_q + 32'd1;

	// Sums with carry out for saturation
	assign sum_add = {1'b0, sum_q} + {33'd0, smp.rtt};
	assign sq_add  = {1'b0, sq_q} + {33'd0, smp.rtt_sq};
	assign diff    = (smp.rtt >= prev_q) ? smp.rtt - prev_q : prev_q - smp.rtt;
	assign jit_add = {1'b0, jit_q} + {33'd0, diff};

	// High latency run
	assign over_spike = smp.rtt > cfg.spike_threshold;
	assign run_inc    = run_q + 1'b1;
	assign run_hit    = over_spike && (run_inc >= RUN_W'(HIGH_RUN_LIMIT));
	assign run_nx     = (!over_spike || run_hit) ? '0 : run_inc;

	// Event flags for a reply or a timeout
	always_comb begin
		ev_nx = '0;
		if (smp.timed_out) begin
			ev_nx.lost = prev_valid_q;
		end else begin
			ev_nx.reconnect       = !prev_valid_q && (sent_q != 32'd0);
			ev_nx.doubled         = prev_valid_q && (prev_q != 16'd0)
			                        && ({1'b0, smp.rtt} > {prev_q, 1'b0})
			                        && (smp.rtt > JUMP_FLOOR_MS);
			ev_nx.persistent_high = run_hit;
			ev_nx.alert           = cfg.alert_enable
			                        && (smp.rtt > cfg.alert_threshold);
		end
	end

	// Commit one sample to the statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q       <= '0;
			lost_q       <= '0;
			sum_q        <= '0;
			sq_q         <= '0;
			jit_q        <= '0;
			min_q        <= '1;
			max_q        <= '0;
			prev_valid_q <= 1'b0;
			prev_q       <= '0;
			run_q        <= '0;
			ev_q         <= '0;
		end else if (upd_en) begin
			sent_q <= sent_nx;
			ev_q   <= ev_nx;
			if (smp.timed_out) begin
				lost_q       <= lost_nx;
				run_q        <= '0;
				prev_valid_q <= 1'b0;
				prev_q       <= '0;
			end else begin
				sum_q <= sum_add[48] ? '1 : sum_add[47:0];
				sq_q  <= sq_add[64] ? '1 : sq_add[63:0];
				if (prev_valid_q) begin
					jit_q <= jit_add[48] ? '1 : jit_add[47:0];
				end
				if (smp.rtt < min_q) begin
					min_q <= smp.rtt;
				end
				if (smp.rtt > max_q) begin
					max_q <= smp.rtt;
				end
				run_q        <= run_nx;
				prev_valid_q <= 1'b1;
				prev_q       <= smp.rtt;
			end
		end
	end

	assign total_sent         = sent_q;
	assign total_lost         = lost_q;
	assign latency_sum        = sum_q;
	assign latency_square_sum = sq_q;
	assign jitter_sum         = jit_q;
	assign min_rtt            = min_q;
	assign max_rtt            = max_q;
	assign ev                 = ev_q;

endmodule

>>> sv/latency_statistics_monitor_core.sv
// Latency statistics monitor.
// Input channel: one word per probe (timed_out, rtt_ms) under in_valid / in_stall.
// Output channel: one word per probe under out_valid / out_stall, giving the
// running counts, saturating sums, min / max rtt and one-shot event flags
// as they stand after that probe.
// Path: a word passes two stages, the input register with the rtt square, then the
// statistics update into the result registers, which feed the next update.
// Throughput: one word per cycle while the output is not stalled.
// The input side keeps accepting while a result waits, as long as the input
// register is free.
// Stall: when out_stall is high the result holds; one more word is taken into
// the input register, then in_stall rises until the output drains.
// Reset (arst_n low): counts and sums clear, min_rtt goes to 65535, max_rtt to
// 0, thresholds to 200, alerts off; no word is in flight.
// Thresholds are set through the APB port (0x0 spike, 0x4 alert, 0x8 enable).
// The user must set them only while no word is in flight (not enforced here).
module latency_statistics_monitor_core
	import lsm_pkg::*;
#(
	parameter int HIGH_RUN_LIMIT = 30
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              timed_out,
	input  logic [15:0]       rtt_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       total_sent,
	output logic [31:0]       total_lost,
	output logic [47:0]       latency_sum,
	output logic [63:0]       latency_square_sum,
	output logic [47:0]       jitter_sum,
	output logic [15:0]       min_rtt,
	output logic [15:0]       max_rtt,
	output logic              lost_event,
	output logic              reconnect_event,
	output logic              doubled_event,
	output logic              persistent_high_event,
	output logic              alert_event
);

	cfg_t    cfg;
	sample_t smp_s1;
	logic    valid_s1;
	logic    out_valid_q;
	logic    advance, move, in_acc;
	events_t ev;

	lsm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Handshake: output register frees when empty or taken
	assign advance  = !out_valid_q || !out_stall;
	assign move     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Capture the word and square the rtt
	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_s1.timed_out <= timed_out;
			smp_s1.rtt       <= rtt_ms;
			smp_s1.rtt_sq    <= rtt_ms * rtt_ms;
		end
	end

	lsm_update #(
		.HIGH_RUN_LIMIT(HIGH_RUN_LIMIT)
	) u_update (
		.clk               (clk),
		.arst_n            (arst_n),
		.upd_en            (move),
		.smp               (smp_s1),
		.cfg               (cfg),
		.total_sent        (total_sent),
		.total_lost        (total_lost),
		.latency_sum       (latency_sum),
		.latency_square_sum(latency_square_sum),
		.jitter_sum        (jitter_sum),
		.min_rtt           (min_rtt),
		.max_rtt           (max_rtt),
		.ev                (ev)
	);

	assign out_valid             = out_valid_q;
	assign lost_event            = ev.lost;
	assign reconnect_event       = ev.reconnect;
	assign doubled_event         = ev.doubled;
	assign persistent_high_event = ev.persistent_high;
	assign alert_event           = ev.alert;

	// Timeouts are counted only alongside probes
	a_lost_le_sent: assert property (@(posedge clk) disable iff (!arst_n)
		total_lost <= total_sent)
		else $error("lost count above sent count");

	// A loss event never shares a word with a reply event
	a_event_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lost_event |-> !(reconnect_event || doubled_event
		|| persistent_high_event || alert_event))
		else $error("loss event together with reply event");

	// A loss event implies a counted timeout
	a_lost_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lost_event |-> total_lost != 32'd0)
		else $error("loss event without timeout count");

	// Input stalls only behind a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

endmodule
